/* design/glob_wildcard_matcher_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the glob wildcard matcher
// Shared property wrappers, clocked and disabled by the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_CORE_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_CORE_MACROS_SVH

// same-cycle implication
`define GWM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GWM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gwm_pkg.sv */
// ----------------------------------------------------------------------------
// gwm_pkg
// Request codes, symbol constants and the queued request type.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam logic [1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_PATH   = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] symbol;
    } cmd_t;

endpackage

/* design/gwm_front.sv */
// ----------------------------------------------------------------------------
// gwm_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_core_macros.svh"

module gwm_front
    import gwm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_symbol,
    output logic       q_valid,
    input  logic       q_ready,
    output cmd_t       q_cmd
);

    localparam int QDEPTH = 2;

    cmd_t       queue_mem [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       cls_cmd;

    // ignored symbols are cleared
    always_comb begin
        cls_cmd.func = s_func;
        unique case (s_func)
            FUNC_APPEND, FUNC_PATH: cls_cmd.symbol = s_symbol;
            FUNC_BEGIN, FUNC_END:   cls_cmd.symbol = 8'h00;
            default:                cls_cmd.symbol = 8'h00;
        endcase
    end

    assign s_ready = (count_reg != 2'(QDEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign q_cmd   = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= cls_cmd;
        end
    end

    `GWM_ASSERT_NXT(a_q_drain, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 2'd1, "queue count did not drop on pop")

endmodule

/* design/gwm_back.sv */
// ----------------------------------------------------------------------------
// gwm_back
// Pattern cells, position-set update and the result register.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_core_macros.svh"

module gwm_back
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output logic m_valid,
    input  logic m_ready,
    output logic m_matched,
    output logic m_pattern_overflow
);

    localparam int NP = PATTERN_MAX + 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]    store_mem [PATTERN_MAX];
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [NP-1:0] raw_reg, raw_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_matched_reg, m_matched_next;
    logic          m_ovf_reg, m_ovf_next;

    logic [NP-1:0] star_v, adv_v, closed, stepped;
    logic          pop, out_free, wr_en, has_room;

    // per-cell classification
    always_comb begin
        star_v = '0;
        adv_v  = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LW'(i) < len_reg) begin
                star_v[i] = (store_mem[i] == SYM_STAR);
                adv_v[i]  = (store_mem[i] != SYM_STAR)
                    && ((store_mem[i] == SYM_ANY) || (store_mem[i] == q_cmd.symbol));
            end
        end
    end

    // star closure via carry chain through runs of star cells
    assign closed  = raw_reg | (((raw_reg & star_v) + star_v) ^ star_v);
    assign stepped = (closed & star_v) | ((closed & adv_v) << 1);

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (q_cmd.func != FUNC_END) || out_free;
    assign pop      = q_valid && q_ready;
    assign has_room = (len_reg < LW'(PATTERN_MAX));
    assign wr_en    = pop && (q_cmd.func == FUNC_APPEND) && has_room;

    always_comb begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        raw_next       = raw_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_matched_next = m_matched_reg;
        m_ovf_next     = m_ovf_reg;
        if (pop) begin
            unique case (q_cmd.func)
                FUNC_BEGIN: begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    raw_next = NP'(1);
                end
                FUNC_APPEND: begin
                    if (has_room) begin
                        len_next = len_reg + LW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    raw_next = NP'(1);
                end
                FUNC_PATH: begin
                    raw_next = stepped;
                end
                FUNC_END: begin
                    m_valid_next   = 1'b1;
                    m_matched_next = closed[len_reg];
                    m_ovf_next     = ovf_reg;
                    raw_next       = NP'(1);
                end
                default: begin
                    raw_next = raw_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            raw_reg     <= NP'(1);
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            raw_reg     <= raw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_matched_reg <= m_matched_next;
        m_ovf_reg     <= m_ovf_next;
        if (wr_en) begin
            store_mem[len_reg[IW-1:0]] <= q_cmd.symbol;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_ovf_reg;

    `GWM_ASSERT_NXT(a_end_result, aclk, aresetn, pop && (q_cmd.func == FUNC_END), m_valid_reg, "end request left no result")
    `GWM_ASSERT_IMP(a_ovf_full, aclk, aresetn, ovf_reg, len_reg == LW'(PATTERN_MAX), "overflow flagged below capacity")
    `GWM_ASSERT_NXT(a_rearm, aclk, aresetn, pop && (q_cmd.func != FUNC_PATH), raw_reg == NP'(1), "position set not rearmed")

endmodule

/* design/glob_wildcard_matcher_core.sv */
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_core
// Streams a path on a loaded '*'/'?' pattern, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                                   Carries
// s_       in   s_valid s_ready s_func s_symbol         pattern/path requests
// m_       out  m_valid m_ready m_matched               match result per end
//                m_pattern_overflow
//
// One request per cycle sustained unless a held result stalls; the position-set
// update of the back end (per-cell compare plus a carry-chain star closure) is
// combinational. A request passes through the queue, then the result register.
// Reset: synchronous, active low; empty pattern, only start position set.
// Stalls: a held result stalls an end request at the queue head and all behind
// it; the queue holds that request and one more.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_core
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_symbol,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic       m_pattern_overflow
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    gwm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_symbol (s_symbol),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    gwm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_cmd              (q_cmd),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

endmodule
